// File: hw/rtl/text_to_oled_column_stream_assert.svh
// assertion macros for the text to oled column stream block
`ifndef TEXT_TO_OLED_COLUMN_STREAM_ASSERT_SVH
`define TEXT_TO_OLED_COLUMN_STREAM_ASSERT_SVH

// checked at every edge outside reset
`define TOCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define TOCS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: hw/rtl/tocs_pkg.sv
package tocs_pkg;

  // display geometry and glyph size
  localparam int GLYPH_WIDTH = 5;
  localparam int COLUMNS     = 128;
  localparam int PAGES       = 8;

  // field widths
  localparam int PAGE_W      = 3;
  localparam int COL_W       = 8;
  localparam int BYTE_W      = 8;
  localparam int GLYPH_IDX_W = 7;
  localparam int CNT_W       = 3;
  localparam int FONT_COLS   = 5;

  // job queue
  localparam int JOBQ_DEPTH = 2;
  localparam int JOBQ_AW    = (JOBQ_DEPTH > 1) ? $clog2(JOBQ_DEPTH) : 1;

  // last step index inside each run
  localparam logic [CNT_W-1:0] CURSOR_LAST   = CNT_W'(5);
  localparam logic [CNT_W-1:0] CONTRAST_LAST = CNT_W'(1);
  localparam logic [CNT_W-1:0] GLYPH_LAST    = CNT_W'(GLYPH_WIDTH);

  // command and character codes
  localparam logic [BYTE_W-1:0] CMD_COL_ADDR  = 8'h21;
  localparam logic [BYTE_W-1:0] CMD_PAGE_ADDR = 8'h22;
  localparam logic [BYTE_W-1:0] CMD_CONTRAST  = 8'h81;
  localparam logic [BYTE_W-1:0] CHAR_NEWLINE  = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_FIRST    = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_LAST     = 8'h7F;
  localparam logic [BYTE_W-1:0] BLANK_COL     = 8'h00;

  // request codes
  typedef enum logic [1:0] {
    REQ_PRINT    = 2'd0,
    REQ_CURSOR   = 2'd1,
    REQ_CONTRAST = 2'd2
  } req_e;

  // back end sequencer phases
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_CURSOR,
    PH_GLYPH,
    PH_CONTRAST
  } phase_e;

  // one classified request
  typedef struct packed {
    logic                   has_cursor;
    logic                   has_glyph;
    logic                   is_contrast;
    logic [PAGE_W-1:0]      page;
    logic [COL_W-1:0]       col;
    logic [GLYPH_IDX_W-1:0] glyph;
    logic [BYTE_W-1:0]      value;
  } job_t;

  // one result beat
  typedef struct packed {
    logic              is_command;
    logic [BYTE_W-1:0] byte_value;
    logic              last_of_run;
  } beat_t;

  // 5x8 font, columns left to right from the top byte
  function automatic logic [8*FONT_COLS-1:0] font_row(input logic [GLYPH_IDX_W-1:0] idx);
    logic [8*FONT_COLS-1:0] row;
    unique case (idx)
      7'd0:  row = 40'h0000000000;
      7'd1:  row = 40'h00005f0000;
      7'd2:  row = 40'h0007000700;
      7'd3:  row = 40'h147f147f14;
      7'd4:  row = 40'h242a7f2a12;
      7'd5:  row = 40'h2313086462;
      7'd6:  row = 40'h3649552250;
      7'd7:  row = 40'h0005030000;
      7'd8:  row = 40'h001c224100;
      7'd9:  row = 40'h0041221c00;
      7'd10: row = 40'h14083e0814;
      7'd11: row = 40'h08083e0808;
      7'd12: row = 40'h0050300000;
      7'd13: row = 40'h0808080808;
      7'd14: row = 40'h0060600000;
      7'd15: row = 40'h2010080402;
      7'd16: row = 40'h3e5149453e;
      7'd17: row = 40'h00427f4000;
      7'd18: row = 40'h4261514946;
      7'd19: row = 40'h2141454b31;
      7'd20: row = 40'h1814127f10;
      7'd21: row = 40'h2745454539;
      7'd22: row = 40'h3c4a494930;
      7'd23: row = 40'h0171090503;
      7'd24: row = 40'h3649494936;
      7'd25: row = 40'h064949291e;
      7'd26: row = 40'h0036360000;
      7'd27: row = 40'h0056360000;
      7'd28: row = 40'h0814224100;
      7'd29: row = 40'h1414141414;
      7'd30: row = 40'h0041221408;
      7'd31: row = 40'h0201510906;
      7'd32: row = 40'h324979413e;
      7'd33: row = 40'h7e1111117e;
      7'd34: row = 40'h7f49494936;
      7'd35: row = 40'h3e41414122;
      7'd36: row = 40'h7f4141221c;
      7'd37: row = 40'h7f49494941;
      7'd38: row = 40'h7f09090901;
      7'd39: row = 40'h3e4149497a;
      7'd40: row = 40'h7f0808087f;
      7'd41: row = 40'h00417f4100;
      7'd42: row = 40'h2040413f01;
      7'd43: row = 40'h7f08142241;
      7'd44: row = 40'h7f40404040;
      7'd45: row = 40'h7f020c027f;
      7'd46: row = 40'h7f0408107f;
      7'd47: row = 40'h3e4141413e;
      7'd48: row = 40'h7f09090906;
      7'd49: row = 40'h3e4151215e;
      7'd50: row = 40'h7f09192946;
      7'd51: row = 40'h4649494931;
      7'd52: row = 40'h01017f0101;
      7'd53: row = 40'h3f4040403f;
      7'd54: row = 40'h1f2040201f;
      7'd55: row = 40'h3f4038403f;
      7'd56: row = 40'h6314081463;
      7'd57: row = 40'h0708700807;
      7'd58: row = 40'h6151494543;
      7'd59: row = 40'h007f414100;
      7'd60: row = 40'h0204081020;
      7'd61: row = 40'h0041417f00;
      7'd62: row = 40'h0402010204;
      7'd63: row = 40'h4040404040;
      7'd64: row = 40'h0001020400;
      7'd65: row = 40'h2054545478;
      7'd66: row = 40'h7f48444438;
      7'd67: row = 40'h3844444420;
      7'd68: row = 40'h384444487f;
      7'd69: row = 40'h3854545418;
      7'd70: row = 40'h087e090102;
      7'd71: row = 40'h0c5252523e;
      7'd72: row = 40'h7f08040478;
      7'd73: row = 40'h00447d4000;
      7'd74: row = 40'h2040443d00;
      7'd75: row = 40'h7f10284400;
      7'd76: row = 40'h00417f4000;
      7'd77: row = 40'h7c04180478;
      7'd78: row = 40'h7c08040478;
      7'd79: row = 40'h3844444438;
      7'd80: row = 40'h7c14141408;
      7'd81: row = 40'h081414147c;
      7'd82: row = 40'h7c08040408;
      7'd83: row = 40'h4854545420;
      7'd84: row = 40'h043f444020;
      7'd85: row = 40'h3c4040207c;
      7'd86: row = 40'h1c2040201c;
      7'd87: row = 40'h3c4030403c;
      7'd88: row = 40'h4428102844;
      7'd89: row = 40'h0c5050503c;
      7'd90: row = 40'h4464544c44;
      7'd91: row = 40'h0008364100;
      7'd92: row = 40'h00007f0000;
      7'd93: row = 40'h0041360800;
      7'd94: row = 40'h1008081008;
      default: row = 40'h0000000000;
    endcase
    return row;
  endfunction

  // one column of a glyph
  function automatic logic [BYTE_W-1:0] font_col(input logic [GLYPH_IDX_W-1:0] idx,
                                                 input logic [CNT_W-1:0] col);
    logic [8*FONT_COLS-1:0] row;
    logic [BYTE_W-1:0]      res;
    row = font_row(idx);
    res = BLANK_COL;
    for (int i = 0; i < FONT_COLS; i++) begin
      if (col == CNT_W'(i)) begin
        res = row[8*(FONT_COLS-1-i) +: 8];
      end
    end
    return res;
  endfunction

endpackage

// File: hw/rtl/tocs_front.sv
module tocs_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic                         q_full_i,
  input  logic [1:0]                   req_type_i,
  input  logic [7:0]                   char_code_i,
  input  logic [7:0]                   target_page_i,
  input  logic [7:0]                   target_column_i,
  input  logic [7:0]                   contrast_value_i,
  output logic                         job_push_o,
  output tocs_pkg::job_t               job_o
);

  logic [tocs_pkg::PAGE_W-1:0] page_q, page_d;
  logic [tocs_pkg::COL_W-1:0]  col_q, col_d;
  logic                        accept;
  logic                        nl;
  logic                        adv;
  logic                        in_rom;
  logic                        cur_ok;
  logic [tocs_pkg::PAGE_W-1:0] page_inc;
  logic [tocs_pkg::COL_W-1:0]  col_base;
  tocs_pkg::job_t              job;

  assign accept = push_i && !q_full_i;

  // line advance and glyph lookup
  assign nl     = (char_code_i == tocs_pkg::CHAR_NEWLINE);
  assign adv    = nl || (({1'b0, col_q} + 9'(tocs_pkg::GLYPH_WIDTH)) >= 9'(tocs_pkg::COLUMNS));
  assign in_rom = (char_code_i >= tocs_pkg::CHAR_FIRST) && (char_code_i <= tocs_pkg::CHAR_LAST);
  assign cur_ok = (target_page_i < 8'(tocs_pkg::PAGES)) &&
                  (target_column_i < 8'(tocs_pkg::COLUMNS));
  assign page_inc = (page_q == tocs_pkg::PAGE_W'(tocs_pkg::PAGES - 1)) ?
                    '0 : page_q + tocs_pkg::PAGE_W'(1);
  assign col_base = adv ? '0 : col_q;

  // classify the request into a job and the next cursor
  always_comb begin
    job             = '0;
    job.value       = contrast_value_i;
    job.glyph       = in_rom ? tocs_pkg::GLYPH_IDX_W'(char_code_i - tocs_pkg::CHAR_FIRST) : '0;
    page_d          = page_q;
    col_d           = col_q;
    unique case (tocs_pkg::req_e'(req_type_i))
      tocs_pkg::REQ_PRINT: begin
        job.has_cursor = adv;
        job.has_glyph  = !nl;
        job.page       = page_inc;
        job.col        = '0;
        if (adv) begin
          page_d = page_inc;
        end
        col_d = nl ? '0 : col_base + tocs_pkg::COL_W'(tocs_pkg::GLYPH_WIDTH + 1);
      end
      tocs_pkg::REQ_CURSOR: begin
        job.has_cursor = cur_ok;
        job.page       = target_page_i[tocs_pkg::PAGE_W-1:0];
        job.col        = target_column_i;
        if (cur_ok) begin
          page_d = target_page_i[tocs_pkg::PAGE_W-1:0];
          col_d  = target_column_i;
        end
      end
      tocs_pkg::REQ_CONTRAST: begin
        job.is_contrast = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign job_o      = job;
  assign job_push_o = accept && (job.has_cursor || job.has_glyph || job.is_contrast);

  // cursor registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_q <= '0;
      col_q  <= '0;
    end else if (accept) begin
      page_q <= page_d;
      col_q  <= col_d;
    end
  end

endmodule

// File: hw/rtl/tocs_jobq.sv
module tocs_jobq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  tocs_pkg::job_t wr_data_i,
  input  logic           rd_i,
  output tocs_pkg::job_t rd_data_o,
  output logic           full_o,
  output logic           empty_o
);

  tocs_pkg::job_t               mem_q [tocs_pkg::JOBQ_DEPTH];
  logic [tocs_pkg::JOBQ_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [tocs_pkg::JOBQ_AW:0]   cnt_q;
  logic                         do_wr, do_rd;

  assign full_o    = (cnt_q == (tocs_pkg::JOBQ_AW+1)'(tocs_pkg::JOBQ_DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == tocs_pkg::JOBQ_AW'(tocs_pkg::JOBQ_DEPTH - 1)) ?
                    '0 : wr_ptr_q + tocs_pkg::JOBQ_AW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == tocs_pkg::JOBQ_AW'(tocs_pkg::JOBQ_DEPTH - 1)) ?
                    '0 : rd_ptr_q + tocs_pkg::JOBQ_AW'(1);
      end
      unique case ({do_wr, do_rd})
        2'b10:   cnt_q <= cnt_q + (tocs_pkg::JOBQ_AW+1)'(1);
        2'b01:   cnt_q <= cnt_q - (tocs_pkg::JOBQ_AW+1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// File: hw/rtl/tocs_back.sv
module tocs_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_empty_i,
  input  tocs_pkg::job_t  q_data_i,
  output logic            q_rd_o,
  input  logic            out_pop_i,
  output logic            out_valid_o,
  output tocs_pkg::beat_t out_beat_o
);

  tocs_pkg::phase_e            phase_q, phase_d;
  logic [tocs_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  tocs_pkg::job_t              job_q, job_d;
  logic                        ovalid_q, ovalid_d;
  tocs_pkg::beat_t             obeat_q;
  tocs_pkg::beat_t             beat;
  logic                        out_free;
  logic                        emit;
  logic                        take;
  tocs_pkg::phase_e            start_ph;

  assign out_free = !ovalid_q || out_pop_i;
  assign start_ph = q_data_i.has_cursor ? tocs_pkg::PH_CURSOR :
                    q_data_i.has_glyph  ? tocs_pkg::PH_GLYPH  : tocs_pkg::PH_CONTRAST;

  // byte selection, step sequencing and job fetch
  always_comb begin
    beat     = '0;
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    job_d    = job_q;
    emit     = 1'b0;
    take     = 1'b0;
    unique case (phase_q)
      tocs_pkg::PH_IDLE: begin
        take = !q_empty_i;
      end
      tocs_pkg::PH_CURSOR: begin
        emit            = out_free;
        beat.is_command = 1'b1;
        unique case (cnt_q)
          3'd0:    beat.byte_value = tocs_pkg::CMD_COL_ADDR;
          3'd1:    beat.byte_value = job_q.col;
          3'd2:    beat.byte_value = tocs_pkg::BYTE_W'(tocs_pkg::COLUMNS - 1);
          3'd3:    beat.byte_value = tocs_pkg::CMD_PAGE_ADDR;
          3'd4:    beat.byte_value = tocs_pkg::BYTE_W'(job_q.page);
          default: beat.byte_value = tocs_pkg::BYTE_W'(tocs_pkg::PAGES - 1);
        endcase
        beat.last_of_run = (cnt_q == tocs_pkg::CURSOR_LAST) && !job_q.has_glyph;
        if (emit) begin
          if (cnt_q == tocs_pkg::CURSOR_LAST) begin
            if (job_q.has_glyph) begin
              phase_d = tocs_pkg::PH_GLYPH;
              cnt_d   = '0;
            end else begin
              take    = !q_empty_i;
              phase_d = tocs_pkg::PH_IDLE;
            end
          end else begin
            cnt_d = cnt_q + tocs_pkg::CNT_W'(1);
          end
        end
      end
      tocs_pkg::PH_GLYPH: begin
        emit             = out_free;
        beat.is_command  = 1'b0;
        beat.byte_value  = (cnt_q < tocs_pkg::GLYPH_LAST) ?
                           tocs_pkg::font_col(job_q.glyph, cnt_q) : tocs_pkg::BLANK_COL;
        beat.last_of_run = (cnt_q == tocs_pkg::GLYPH_LAST);
        if (emit) begin
          if (cnt_q == tocs_pkg::GLYPH_LAST) begin
            take    = !q_empty_i;
            phase_d = tocs_pkg::PH_IDLE;
          end else begin
            cnt_d = cnt_q + tocs_pkg::CNT_W'(1);
          end
        end
      end
      tocs_pkg::PH_CONTRAST: begin
        emit             = out_free;
        beat.is_command  = 1'b1;
        beat.byte_value  = (cnt_q == '0) ? tocs_pkg::CMD_CONTRAST : job_q.value;
        beat.last_of_run = (cnt_q == tocs_pkg::CONTRAST_LAST);
        if (emit) begin
          if (cnt_q == tocs_pkg::CONTRAST_LAST) begin
            take    = !q_empty_i;
            phase_d = tocs_pkg::PH_IDLE;
          end else begin
            cnt_d = cnt_q + tocs_pkg::CNT_W'(1);
          end
        end
      end
      default: begin
        phase_d = tocs_pkg::PH_IDLE;
      end
    endcase
    // next job starts right after the last byte of this one
    if (take) begin
      job_d   = q_data_i;
      phase_d = start_ph;
      cnt_d   = '0;
    end
  end

  assign q_rd_o   = take;
  assign ovalid_d = emit || (ovalid_q && !out_pop_i);

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= tocs_pkg::PH_IDLE;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  // job and output beat payload
  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    if (emit) begin
      obeat_q <= beat;
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_beat_o  = obeat_q;

endmodule

// File: hw/rtl/text_to_oled_column_stream.sv
// first byte of a request goes via job queue, job register and result register to the ports
// throughput: one result byte per cycle while results are popped; a request causes 2, 6
//   or 12 bytes, and a request that causes none is not queued; the byte sequencer in
//   the back end sets this figure
// a two-entry job queue lets requests be taken while earlier ones are still being sent
// reset (rst_ni low, asynchronous): cursor to page 0 column 0, queue and result slot empty
module text_to_oled_column_stream (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [1:0] req_type_i,
  input  logic [7:0] char_code_i,
  input  logic [7:0] target_page_i,
  input  logic [7:0] target_column_i,
  input  logic [7:0] contrast_value_i,
  output logic       empty,
  input  logic       pop,
  output logic       is_command_o,
  output logic [7:0] byte_value_o,
  output logic       last_of_run_o
);

  logic            job_push;
  tocs_pkg::job_t  job_in;
  tocs_pkg::job_t  job_out;
  logic            q_full, q_empty, q_rd;
  logic            out_valid;
  tocs_pkg::beat_t out_beat;

  // request classifier and cursor
  tocs_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push),
    .q_full_i         (q_full),
    .req_type_i       (req_type_i),
    .char_code_i      (char_code_i),
    .target_page_i    (target_page_i),
    .target_column_i  (target_column_i),
    .contrast_value_i (contrast_value_i),
    .job_push_o       (job_push),
    .job_o            (job_in)
  );

  // job queue between front and back
  tocs_jobq u_jobq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (job_push),
    .wr_data_i (job_in),
    .rd_i      (q_rd),
    .rd_data_o (job_out),
    .full_o    (q_full),
    .empty_o   (q_empty)
  );

  // byte sequencer
  tocs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (job_out),
    .q_rd_o      (q_rd),
    .out_pop_i   (pop),
    .out_valid_o (out_valid),
    .out_beat_o  (out_beat)
  );

  assign full          = q_full;
  assign empty         = !out_valid;
  assign is_command_o  = out_beat.is_command;
  assign byte_value_o  = out_beat.byte_value;
  assign last_of_run_o = out_beat.last_of_run;

endmodule

// File: hw/rtl/tocs_checker.sv
`include "text_to_oled_column_stream_assert.svh"

module tocs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       push,
  input logic       full,
  input logic [1:0] req_type_i,
  input logic [7:0] char_code_i,
  input logic [7:0] target_page_i,
  input logic [7:0] target_column_i,
  input logic [7:0] contrast_value_i,
  input logic       empty,
  input logic       pop,
  input logic       is_command_o,
  input logic [7:0] byte_value_o,
  input logic       last_of_run_o
);

  // a waiting result beat holds until popped
  `TOCS_ASSERT(a_hold_beat, (!empty && !pop) |=> (!empty && $stable(byte_value_o) && $stable(is_command_o) && $stable(last_of_run_o)), "result beat changed while stalled")

  // reset leaves the result slot empty and the queue not full
  `TOCS_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> (empty && !full), "not empty in reset")

  // within a glyph data run, no command beat follows a data beat that is not the last
  `TOCS_ASSERT(a_glyph_run, (!empty && pop && !is_command_o && !last_of_run_o) |=> (empty || !is_command_o), "command inside glyph run")

  // contrast command is followed by its value as the last beat
  `TOCS_ASSERT(a_contrast_pair, (!empty && pop && is_command_o && byte_value_o == 8'h81 && !last_of_run_o) |=> (empty || (is_command_o && last_of_run_o)), "contrast value missing")

endmodule

bind text_to_oled_column_stream tocs_checker u_tocs_checker (.*);
